[rtl/core/abop_pkg.sv]
`timescale 1ns / 1ps

package abop_pkg;

  localparam int DEF_MAX_BUCKETS = 8;
  localparam int DEF_OFFSET_BITS = 48;

  localparam int LEN_W   = 48;
  localparam int CNT_W   = 32;
  localparam int ALIGN_W = 32;
  localparam int BKT_W   = 4;
  localparam int BCNT_W  = 4;
  localparam int CFG_W   = 32;
  localparam int CFGA_W  = 1;

  localparam logic [BCNT_W-1:0]  RST_BUCKET_COUNT = BCNT_W'(8);
  localparam logic [ALIGN_W-1:0] RST_ALIGNMENT    = ALIGN_W'(256);

  localparam logic [CFGA_W-1:0] REG_BUCKET_COUNT = 1'b0;
  localparam logic [CFGA_W-1:0] REG_ALIGNMENT    = 1'b1;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BUCKET   = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_ALIGN,
    S_PAD,
    S_END,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } bank_ctrl_t;

endpackage

[rtl/core/abop_rem.sv]
`timescale 1ns / 1ps

module abop_rem #(
  parameter int OFFSET_BITS = abop_pkg::DEF_OFFSET_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [OFFSET_BITS-1:0]       dividend,
  input  logic [abop_pkg::ALIGN_W-1:0] divisor,
  output logic                         done,
  output logic [abop_pkg::ALIGN_W-1:0] rem
);
  import abop_pkg::*;

  localparam int CW = $clog2(OFFSET_BITS + 1);

  logic [OFFSET_BITS-1:0] dq;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic [ALIGN_W:0]       trial;
  logic                   fits;

  assign trial = {rem, dq[OFFSET_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(OFFSET_BITS);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (busy) begin
      dq  <= dq << 1;
      rem <= fits ? ALIGN_W'(trial - {1'b0, divisor}) : trial[ALIGN_W-1:0];
    end
  end

endmodule

[rtl/core/abop_bank.sv]
`timescale 1ns / 1ps

module abop_bank #(
  parameter int MAX_BUCKETS = abop_pkg::DEF_MAX_BUCKETS,
  parameter int IW          = 1,
  parameter int EW          = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  abop_pkg::bank_ctrl_t ctrl,
  input  logic [IW-1:0]        addr,
  input  logic [EW-1:0]        wdata,
  output logic [EW-1:0]        rdata
);
  import abop_pkg::*;

  logic [EW-1:0]          mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] vld;
  logic [EW-1:0]          rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctrl.rd) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      vld <= '0;
    end else if (ctrl.wr) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_vld <= vld[addr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

[rtl/core/aligned_bucket_offset_allocator_top.sv]
`timescale 1ns / 1ps

// Per-bucket bump allocator. A place beat rounds its bucket's cursor up to the next
// multiple of the alignment register (any value; zero means no rounding), returns that
// offset and advances the cursor by the length; a clear beat zeroes every bucket at once.
// One beat is handled at a time. A place with nonzero alignment reads its bucket, then
// the remainder unit takes one cursor bit per cycle; the cursor is padded, the end is
// checked and the bucket is written back. Padding is skipped when the cursor is already
// aligned, and an overflow stops the beat before the write. Zero alignment skips the
// remainder unit; a clear or a rejected bucket goes straight to the result. A finished
// result sits in an output register, so the next beat is accepted while it waits. Write
// the configuration registers only while idle.
module aligned_bucket_offset_allocator_top #(
  parameter int MAX_BUCKETS = abop_pkg::DEF_MAX_BUCKETS,
  parameter int OFFSET_BITS = abop_pkg::DEF_OFFSET_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [abop_pkg::CFGA_W-1:0]  cfg_addr,
  input  logic [abop_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         cmd,
  input  logic [abop_pkg::BKT_W-1:0]   bucket,
  input  logic [abop_pkg::LEN_W-1:0]   length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [OFFSET_BITS-1:0]       offset,
  output logic [abop_pkg::CNT_W-1:0]   bucket_items,
  output logic [OFFSET_BITS-1:0]       bucket_payload,
  output logic [OFFSET_BITS-1:0]       bucket_end,
  output logic [1:0]                   status
);
  import abop_pkg::*;

  localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int EW = CNT_W + 2 * OFFSET_BITS;
  localparam int SW = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
  localparam logic [SW-1:0] OFF_MAX = SW'({OFFSET_BITS{1'b1}});

  state_t state, state_next;

  logic [BCNT_W-1:0]      bucket_count;
  logic [ALIGN_W-1:0]     alignment;

  logic [IW-1:0]          bkt;
  logic [LEN_W-1:0]       len;
  logic [OFFSET_BITS-1:0] cur;
  logic [CNT_W-1:0]       cnt;
  logic [OFFSET_BITS-1:0] pay;
  logic [ALIGN_W-1:0]     delta;
  logic [OFFSET_BITS-1:0] aligned;

  logic [OFFSET_BITS-1:0] res_offset;
  logic [CNT_W-1:0]       res_items;
  logic [OFFSET_BITS-1:0] res_pay;
  logic [OFFSET_BITS-1:0] res_end;
  logic [1:0]             res_status;

  bank_ctrl_t             bank_ctrl;
  logic [IW-1:0]          bank_addr;
  logic [IW-1:0]          in_idx;
  logic [EW-1:0]          bank_rdata;
  logic [EW-1:0]          bank_wdata;

  logic                   div_start;
  logic                   div_done;
  logic [ALIGN_W-1:0]     div_rem;

  logic                   oor;
  logic                   out_free;
  logic [SW-1:0]          pad_sum;
  logic [SW-1:0]          end_sum;
  logic                   pad_ovf;
  logic                   end_ovf;

  assign in_idx   = IW'(8'(bucket));
  assign oor      = (bucket >= bucket_count) || (8'(bucket) >= 8'(MAX_BUCKETS));
  assign out_free = !out_valid || out_ready;
  assign pad_sum  = SW'(cur) + SW'(delta);
  assign end_sum  = SW'(aligned) + SW'(len);
  assign pad_ovf  = pad_sum > OFF_MAX;
  assign end_ovf  = end_sum > OFF_MAX;

  assign bank_addr  = (state == S_IDLE) ? in_idx : bkt;
  assign bank_wdata = {res_items, res_pay, res_end};

  abop_bank #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .IW          (IW),
    .EW          (EW)
  ) u_bank (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (bank_ctrl),
    .addr  (bank_addr),
    .wdata (bank_wdata),
    .rdata (bank_rdata)
  );

  abop_rem #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bank_rdata[OFFSET_BITS-1:0]),
    .divisor  (alignment),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_CLEAR || oor) ? S_DONE : S_READ;
        end
      end
      S_READ:  state_next = (alignment == '0) ? S_END : S_DIV;
      S_DIV:   state_next = div_done ? S_ALIGN : S_DIV;
      S_ALIGN: state_next = (div_rem == '0) ? S_END : S_PAD;
      S_PAD:   state_next = pad_ovf ? S_DONE : S_END;
      S_END:   state_next = end_ovf ? S_DONE : S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    bank_ctrl.rd  = (state == S_IDLE) && in_valid && (cmd == CMD_PLACE) && !oor;
    bank_ctrl.clr = (state == S_IDLE) && in_valid && (cmd == CMD_CLEAR);
    bank_ctrl.wr  = (state == S_WRITE);
    div_start     = (state == S_READ) && (alignment != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= RST_BUCKET_COUNT;
      alignment    <= RST_ALIGNMENT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BUCKET_COUNT: bucket_count <= cfg_wdata[BCNT_W-1:0];
        REG_ALIGNMENT:    alignment    <= cfg_wdata[ALIGN_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        bkt        <= in_idx;
        len        <= length;
        res_offset <= '0;
        res_items  <= '0;
        res_pay    <= '0;
        res_end    <= '0;
        res_status <= (cmd == CMD_PLACE && oor) ? STAT_BUCKET : STAT_OK;
      end
      S_READ: begin
        res_items <= bank_rdata[EW-1 -: CNT_W];
        res_pay   <= bank_rdata[2*OFFSET_BITS-1 -: OFFSET_BITS];
        res_end   <= bank_rdata[OFFSET_BITS-1:0];
        cnt       <= bank_rdata[EW-1 -: CNT_W];
        pay       <= bank_rdata[2*OFFSET_BITS-1 -: OFFSET_BITS];
        cur       <= bank_rdata[OFFSET_BITS-1:0];
        aligned   <= bank_rdata[OFFSET_BITS-1:0];
      end
      S_ALIGN: begin
        delta <= alignment - div_rem;
      end
      S_PAD: begin
        if (pad_ovf) begin
          res_status <= STAT_OVERFLOW;
        end else begin
          aligned <= pad_sum[OFFSET_BITS-1:0];
        end
      end
      S_END: begin
        if (end_ovf) begin
          res_status <= STAT_OVERFLOW;
        end else begin
          res_offset <= aligned;
          res_items  <= cnt + CNT_W'(1);
          res_pay    <= OFFSET_BITS'(SW'(pay) + SW'(len));
          res_end    <= end_sum[OFFSET_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      offset         <= res_offset;
      bucket_items   <= res_items;
      bucket_payload <= res_pay;
      bucket_end     <= res_end;
      status         <= res_status;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted beat did not start work");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("remainder finished outside divide state");

  a_write_only_ok: assert property (@(posedge clk) disable iff (rst)
    bank_ctrl.wr |-> res_status == STAT_OK)
    else $error("bucket write on a failed placement");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result shown without completion");

endmodule

[tb/aligned_bucket_offset_allocator_top_test.sv]
`timescale 1ns / 1ps

module aligned_bucket_offset_allocator_top_test;
  import abop_pkg::*;

  localparam int OFF_W = DEF_OFFSET_BITS;
  localparam int NBKT = DEF_MAX_BUCKETS;
  localparam logic [63:0] OFF_LIMIT = (64'd1 << OFF_W) - 64'd1;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [CNT_W-1:0] items;
    logic [OFF_W-1:0] payload;
    logic [OFF_W-1:0] end_pos;
    logic [1:0]       status;
  } placement_t;

  class offset_ledger;
    logic [BCNT_W-1:0]  bucket_count;
    logic [ALIGN_W-1:0] alignment;
    logic [OFF_W-1:0]   cursor [NBKT];
    logic [CNT_W-1:0]   item_count [NBKT];
    logic [OFF_W-1:0]   payload_total [NBKT];
    placement_t         expected_placements [$];
    int                 mismatches;

    function new();
      bucket_count = RST_BUCKET_COUNT;
      alignment = RST_ALIGNMENT;
      mismatches = 0;
      clear_buckets();
    endfunction

    function void clear_buckets();
      for (int i = 0; i < NBKT; i++) begin
        cursor[i] = '0;
        item_count[i] = '0;
        payload_total[i] = '0;
      end
    endfunction

    function void set_reg(logic [CFGA_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_BUCKET_COUNT) begin
        bucket_count = value[BCNT_W-1:0];
      end else if (idx == REG_ALIGNMENT) begin
        alignment = value[ALIGN_W-1:0];
      end
    endfunction

    function int pending();
      return expected_placements.size();
    endfunction

    function void note_request(logic c, logic [BKT_W-1:0] b, logic [LEN_W-1:0] len);
      placement_t r;
      logic [63:0] cur, aligned, align_w, rem, delta, len_w;
      bit ovf;
      r = '0;
      ovf = 1'b0;
      if (c == CMD_CLEAR) begin
        clear_buckets();
        r.status = STAT_OK;
      end else if (b >= bucket_count || b >= NBKT) begin
        r.status = STAT_BUCKET;
      end else begin
        cur = 64'(cursor[b]);
        len_w = 64'(len);
        align_w = 64'(alignment);
        aligned = cur;
        if (align_w != 0) begin
          rem = cur % align_w;
          if (rem != 0) begin
            delta = align_w - rem;
            if (delta > OFF_LIMIT - cur) ovf = 1'b1;
            else aligned = cur + delta;
          end
        end
        if (!ovf && len_w > OFF_LIMIT - aligned) ovf = 1'b1;
        if (ovf) begin
          r.items = item_count[b];
          r.payload = payload_total[b];
          r.end_pos = cursor[b];
          r.status = STAT_OVERFLOW;
        end else begin
          cursor[b] = OFF_W'(aligned + len_w);
          item_count[b] = item_count[b] + 1'b1;
          payload_total[b] = payload_total[b] + len;
          r.offset = OFF_W'(aligned);
          r.items = item_count[b];
          r.payload = payload_total[b];
          r.end_pos = cursor[b];
          r.status = STAT_OK;
        end
      end
      expected_placements.push_back(r);
    endfunction

    function void check_placement(placement_t got);
      placement_t exp;
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: offset=%h items=%h payload=%h end=%h status=%0d",
                   got.offset, got.items, got.payload, got.end_pos, got.status);
        return;
      end
      exp = expected_placements.pop_front();
      if (got.offset !== exp.offset || got.items !== exp.items ||
          got.payload !== exp.payload || got.end_pos !== exp.end_pos ||
          got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: offset=%h items=%h payload=%h end=%h status=%0d",
                   exp.offset, exp.items, exp.payload, exp.end_pos, exp.status);
          $display("         got: offset=%h items=%h payload=%h end=%h status=%0d",
                   got.offset, got.items, got.payload, got.end_pos, got.status);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFGA_W-1:0]  cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_PLACE;
  logic [BKT_W-1:0]   bucket = '0;
  logic [LEN_W-1:0]   length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [OFF_W-1:0]   offset;
  logic [CNT_W-1:0]   bucket_items;
  logic [OFF_W-1:0]   bucket_payload;
  logic [OFF_W-1:0]   bucket_end;
  logic [1:0]         status;

  offset_ledger ledger;
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;
  int burst_left = 0;

  aligned_bucket_offset_allocator_top DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : result_sink
    placement_t got;
    int mode, mode_left, tick, hold_left;
    mode = 0;
    mode_left = 0;
    tick = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.offset = offset;
        got.items = bucket_items;
        got.payload = bucket_payload;
        got.end_pos = bucket_end;
        got.status = status;
        ledger.check_placement(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 2500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ((tick % 7) >= 3);
          default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  task automatic offer_beat(input logic c, input logic [BKT_W-1:0] b,
                            input logic [LEN_W-1:0] len);
    in_valid <= 1'b1;
    cmd <= c;
    bucket <= b;
    length <= len;
    do @(posedge clk); while (!in_ready);
    ledger.note_request(c, b, len);
  endtask

  task automatic send_item(input logic c, input logic [BKT_W-1:0] b,
                           input logic [LEN_W-1:0] len);
    int gap;
    offer_beat(c, b, len);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFGA_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic [BCNT_W-1:0] count, input logic [ALIGN_W-1:0] align);
    logic [CFG_W-1:0] upper;
    drain();
    upper = $urandom;
    write_reg(REG_BUCKET_COUNT, {upper[CFG_W-1:BCNT_W], count});
    write_reg(REG_ALIGNMENT, align);
  endtask

  function automatic logic [ALIGN_W-1:0] pick_alignment();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'd1;
      2: return 32'd1 << $urandom_range(1, 16);
      3: return $urandom_range(2, 1000);
      4: return $urandom;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic random_item();
    logic c;
    logic [BKT_W-1:0] b;
    logic [LEN_W-1:0] len;
    int span, pick;
    c = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_PLACE;
    span = (ledger.bucket_count > NBKT) ? NBKT : int'(ledger.bucket_count);
    if (span == 0 || $urandom_range(0, 9) == 0) b = BKT_W'($urandom_range(0, 15));
    else b = BKT_W'($urandom_range(0, span - 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) len = LEN_W'($urandom_range(0, 4095));
    else if (pick < 75) len = LEN_W'($urandom);
    else if (pick < 90) len = LEN_W'({$urandom, $urandom});
    else len = LEN_W'(OFF_LIMIT) - ledger.cursor[b[2:0]] - LEN_W'($urandom_range(0, 3));
    send_item(c, b, len);
  endtask

  initial begin : stimulus
    logic [BCNT_W-1:0] count;
    logic [ALIGN_W-1:0] align;
    ledger = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_PLACE, 4'd0, 48'd0);
    send_item(CMD_PLACE, 4'd0, 48'd1);
    send_item(CMD_PLACE, 4'd0, 48'd100);
    send_item(CMD_PLACE, 4'd7, 48'hFFFF_FFFF_FFFF);
    send_item(CMD_PLACE, 4'd7, 48'd0);
    send_item(CMD_PLACE, 4'd0, 48'hFFFF_FFFF_FFFF);
    send_item(CMD_PLACE, 4'd8, 48'd5);
    send_item(CMD_PLACE, 4'd15, 48'hFFFF_FFFF_FFFF);
    send_item(CMD_CLEAR, 4'hA, 48'h5A5A_A5A5_F00F);
    send_item(CMD_PLACE, 4'd0, 48'd7);

    configure(4'd0, 32'd0);
    send_item(CMD_PLACE, 4'd0, 48'd3);
    configure(4'd15, 32'd0);
    send_item(CMD_PLACE, 4'd7, 48'd3);
    send_item(CMD_PLACE, 4'd7, 48'd5);
    send_item(CMD_PLACE, 4'd8, 48'd1);
    configure(4'd1, 32'd1);
    send_item(CMD_PLACE, 4'd0, 48'd9);
    send_item(CMD_PLACE, 4'd1, 48'd1);
    configure(4'd8, 32'd3);
    send_item(CMD_PLACE, 4'd0, 48'd1);
    send_item(CMD_PLACE, 4'd2, 48'hFFFF_FFFF_FFFE);
    send_item(CMD_PLACE, 4'd2, 48'd0);
    send_item(CMD_PLACE, 4'd2, 48'd1);
    configure(4'd8, 32'hFFFF_FFFF);
    send_item(CMD_PLACE, 4'd0, 48'd5);
    send_item(CMD_PLACE, 4'd3, 48'd0);
    send_item(CMD_CLEAR, 4'd0, 48'd0);

    for (int p = 0; p < 8; p++) begin
      if (p == 1) begin
        count = 4'd8;
        align = '0;
      end else if (p == 2) begin
        count = 4'd1;
        align = 32'hFFFF_FFFF;
      end else begin
        count = ($urandom_range(0, 4) == 0) ? BCNT_W'($urandom_range(0, 15))
                                            : BCNT_W'($urandom_range(1, 8));
        align = pick_alignment();
      end
      configure(count, align);
      gaps_on = (p % 3) != 2;
      for (int i = 0; i < 230; i++) begin
        if (p == 0 && i == 40) hold_request = 1'b1;
        random_item();
      end
    end

    drain();
    repeat (64) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
